@@ hw/rtl/rdc_pkg.sv @@
// Shared types and constants for the range distinct count block.
// Field widths, default sizes and the sequencer state type.
// No dependencies.
package rdc_pkg;

  localparam int unsigned PositionW      = 15;
  localparam int unsigned ValueW         = 16;
  localparam int unsigned CountW         = 16;
  localparam int unsigned InTdataW       = 64;
  localparam int unsigned OutTdataW      = 16;

  localparam int unsigned DefArrayDepth  = 32768;
  localparam int unsigned DefValueRange  = 65536;

  // one-hot sequencer states
  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_REDUCE = 9'b000000100,
    ST_LCHK   = 9'b000001000,
    ST_MOVE   = 9'b000010000,
    ST_CRD    = 9'b000100000,
    ST_CWR    = 9'b001000000,
    ST_LWR    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } rdc_state_e;

endpackage

@@ hw/rtl/range_distinct_count_core.sv @@
// Range distinct count core: element store, per-value count table and window sequencer.
// Depends on rdc_pkg.
//
// The block holds an array of values and answers range queries with the number of
// distinct values between left and right, inclusive. A transfer with tuser = 0 loads
// one element; a transfer with tuser = 1 is a query and yields one result transfer.
// After reset the count table, VALUE_RANGE entries (65536 by default), is swept clear,
// one entry per cycle; no transfer is accepted until that finishes. A load reduces the
// value modulo VALUE_RANGE by a reciprocal multiply, a back-multiply and at most one
// correcting subtract, one step per cycle, and updates the count table only when its
// position lies inside the current window. A query reads the single-port element store
// and then read-modify-writes the single-port count table for every element the window
// edges move; it is held longer while the previous result still waits in the output
// register.
// A finished result sits in the output register while the next transfer is taken.
module range_distinct_count_core
  import rdc_pkg::*;
#(
  parameter int unsigned ARRAY_DEPTH = DefArrayDepth,
  parameter int unsigned VALUE_RANGE = DefValueRange
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [14:0] position, [30:15] value, [45:31] left, [60:46] right, [63:61] zero
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // [0] mode: 0 load, 1 query
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [15:0] distinct_count
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AW  = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int unsigned WW  = AW + 1;
  localparam int unsigned VW  = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int unsigned CW  = $clog2(ARRAY_DEPTH + 1);
  localparam int unsigned SW  = 2;
  // reciprocal of VALUE_RANGE; the estimate is never more than one below the quotient
  localparam int unsigned     RecipS = ValueW + VW;
  localparam longint unsigned RecipM = (64'd1 << RecipS) / 64'(VALUE_RANGE);
  localparam int unsigned     PW     = ValueW + ValueW + 1;

  // input fields
  logic                 in_mode;
  logic [PositionW-1:0] in_pos;
  logic [ValueW-1:0]    in_val;
  logic [PositionW-1:0] in_left;
  logic [PositionW-1:0] in_right;

  assign in_mode  = s_axis_tuser_i[0];
  assign in_pos   = s_axis_tdata_i[14:0];
  assign in_val   = s_axis_tdata_i[30:15];
  assign in_left  = s_axis_tdata_i[45:31];
  assign in_right = s_axis_tdata_i[60:46];

  // memories
  logic [VW-1:0] elem_mem [ARRAY_DEPTH];
  logic [CW-1:0] cnt_mem  [VALUE_RANGE];

  rdc_state_e    state_q, state_d;
  logic [VW-1:0] clr_q, clr_d;
  logic [SW-1:0] step_q, step_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [WW-1:0] start_q, start_d;
  logic [WW-1:0] end_q, end_d;
  logic [WW-1:0] lo_q, lo_d;
  logic [WW-1:0] stop_q, stop_d;
  logic [CW-1:0] total_q, total_d;
  logic          inc_q, inc_d;
  logic          query_q, query_d;
  logic          old_q, old_d;
  logic [VW-1:0] caddr_q, caddr_d;
  logic          out_vld_q, out_vld_d;
  logic [OutTdataW-1:0] out_q, out_d;

  logic          elem_re, elem_we;
  logic [AW-1:0] elem_raddr;
  logic [VW-1:0] elem_rdata_q;
  logic          cnt_re, cnt_we;
  logic [VW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [CW-1:0] cnt_rdata_q;

  logic             accept;
  logic [PW-1:0]    recip_prod;
  logic [WW-1:0]    lo_in, hi_in;
  logic             in_window;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  assign recip_prod = PW'(rem_q) * PW'(RecipM);
  assign in_window  = ({1'b0, pos_q} >= start_q) && ({1'b0, pos_q} < end_q);

  always_comb begin
    lo_in = WW'(32'(in_left));
    hi_in = WW'(32'(in_right));
    if (32'(in_left) > 32'(ARRAY_DEPTH - 1)) begin
      lo_in = WW'(ARRAY_DEPTH - 1);
    end
    if (32'(in_right) > 32'(ARRAY_DEPTH - 1)) begin
      hi_in = WW'(ARRAY_DEPTH - 1);
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    step_d     = step_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    pos_d      = pos_q;
    start_d    = start_q;
    end_d      = end_q;
    lo_d       = lo_q;
    stop_d     = stop_q;
    total_d    = total_q;
    inc_d      = inc_q;
    query_d    = query_q;
    old_d      = old_q;
    caddr_d    = caddr_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    elem_re    = 1'b0;
    elem_we    = 1'b0;
    elem_raddr = pos_q;
    cnt_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = caddr_q;
    cnt_wdata  = '0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + VW'(1);
        if (32'(clr_q) == 32'(VALUE_RANGE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          query_d = in_mode;
          old_d   = 1'b0;
          if (in_mode) begin
            lo_d    = lo_in;
            stop_d  = (lo_in > hi_in) ? lo_in : hi_in + WW'(1);
            state_d = ST_MOVE;
          end else if (32'(in_pos) < 32'(ARRAY_DEPTH)) begin
            pos_d   = AW'(32'(in_pos));
            rem_d   = in_val;
            step_d  = SW'(2);
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // quotient estimate, back-multiply, then at most one correcting subtract
        if (step_q == SW'(2)) begin
          quo_d = ValueW'(recip_prod >> RecipS);
        end else if (step_q == SW'(1)) begin
          rem_d = ValueW'(32'(rem_q) - 32'(quo_q) * 32'(VALUE_RANGE));
        end else if (32'(rem_q) >= 32'(VALUE_RANGE)) begin
          rem_d = ValueW'(32'(rem_q) - 32'(VALUE_RANGE));
        end
        step_d = step_q - SW'(1);
        if (step_q == '0) begin
          state_d = ST_LCHK;
        end
      end
      ST_LCHK: begin
        if (in_window) begin
          elem_re = 1'b1;
          old_d   = 1'b1;
          inc_d   = 1'b0;
          state_d = ST_CRD;
        end else begin
          state_d = ST_LWR;
        end
      end
      ST_MOVE: begin
        // grow first, then shrink, so the window never inverts
        if (start_q > lo_q) begin
          start_d    = start_q - WW'(1);
          elem_raddr = AW'(start_q - WW'(1));
          elem_re    = 1'b1;
          inc_d      = 1'b1;
          state_d    = ST_CRD;
        end else if (end_q < stop_q) begin
          end_d      = end_q + WW'(1);
          elem_raddr = AW'(end_q);
          elem_re    = 1'b1;
          inc_d      = 1'b1;
          state_d    = ST_CRD;
        end else if (start_q < lo_q) begin
          start_d    = start_q + WW'(1);
          elem_raddr = AW'(start_q);
          elem_re    = 1'b1;
          inc_d      = 1'b0;
          state_d    = ST_CRD;
        end else if (end_q > stop_q) begin
          end_d      = end_q - WW'(1);
          elem_raddr = AW'(end_q - WW'(1));
          elem_re    = 1'b1;
          inc_d      = 1'b0;
          state_d    = ST_CRD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_CRD: begin
        caddr_d = (query_q || old_q) ? elem_rdata_q : VW'(rem_q);
        cnt_re  = 1'b1;
        state_d = ST_CWR;
      end
      ST_CWR: begin
        cnt_we = 1'b1;
        if (inc_q) begin
          cnt_wdata = cnt_rdata_q + CW'(1);
          if (cnt_rdata_q == '0) begin
            total_d = total_q + CW'(1);
          end
        end else if (cnt_rdata_q != '0) begin
          cnt_wdata = cnt_rdata_q - CW'(1);
          if (cnt_rdata_q == CW'(1)) begin
            total_d = total_q - CW'(1);
          end
        end else begin
          cnt_wdata = cnt_rdata_q;
        end
        if (query_q) begin
          state_d = ST_MOVE;
        end else if (old_q) begin
          // old value dropped, now count the new one
          old_d   = 1'b0;
          inc_d   = 1'b1;
          state_d = ST_CRD;
        end else begin
          state_d = ST_LWR;
        end
      end
      ST_LWR: begin
        elem_we = 1'b1;
        state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_d     = OutTdataW'(total_q);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      start_q   <= '0;
      end_q     <= '0;
      total_q   <= '0;
      inc_q     <= 1'b0;
      query_q   <= 1'b0;
      old_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      step_q    <= step_d;
      start_q   <= start_d;
      end_q     <= end_d;
      total_q   <= total_d;
      inc_q     <= inc_d;
      query_q   <= query_d;
      old_q     <= old_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    pos_q   <= pos_d;
    lo_q    <= lo_d;
    stop_q  <= stop_d;
    caddr_q <= caddr_d;
    out_q   <= out_d;
  end

  // element store, single port
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[pos_q] <= VW'(rem_q);
    end
    if (elem_re) begin
      elem_rdata_q <= elem_mem[elem_raddr];
    end
  end

  // per-value count table
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[caddr_d];
    end
  end

endmodule
